>>> sv/vlb_pkg.sv
`default_nettype none
package vlb_pkg;
   localparam int HOST_CPUS       = 8;
   localparam int PRIORITY_LEVELS = 8;
   localparam int VCPU_SLOTS      = 64;
   localparam int HW  = $clog2(HOST_CPUS);
   localparam int PW  = $clog2(PRIORITY_LEVELS);
   localparam int SW  = $clog2(VCPU_SLOTS);
   localparam int CW  = SW + 1;
   localparam int NCNT = HOST_CPUS * PRIORITY_LEVELS;
   localparam int NW  = $clog2(NCNT);

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_IDLE   = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;
   localparam logic [1:0] REQ_BAL    = 2'd3;

   localparam logic [1:0] ST_OTHER  = 2'd0;
   localparam logic [1:0] ST_READY  = 2'd1;
   localparam logic [1:0] ST_PAUSED = 2'd3;

   localparam logic [1:0] CSR_CUR   = 2'd0;
   localparam logic [1:0] CSR_MASK  = 2'd1;
   localparam logic [1:0] CSR_BUSY  = 2'd2;
   localparam logic [1:0] CSR_GAP   = 2'd3;

   localparam logic [6:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [15:0] id;
      logic [1:0]  state;
      logic [2:0]  host;
      logic [7:0]  prio;
      logic [7:0]  aff;
   } rec_type;

   typedef struct packed {
      logic        start;
      logic [63:0] idle;
      logic [63:0] period;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [6:0] pct;
   } div_rsp_type;

   function automatic logic [3:0] pop8(input logic [7:0] m);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) c = c + {3'd0, m[i]};
      return c;
   endfunction
endpackage
`default_nettype wire

>>> sv/vcpu_load_balancer.sv
`default_nettype none
// Requests are taken one at a time. A first record also sweeps the count tables; an
// idle sample waits on the divider, done at once for a zero period or full idle.
// A query scans alive counts per host; a balance sums active counts per host, scans
// the idle shares, then may scan the table and make a move (one table port).
// Input is ready in the cycle after an answer is taken. Sync reset clears control,
// sweeps counts.
module vcpu_load_balancer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tuser: req_type[1:0], first_record[2]
   input  wire logic [2:0]  req_tuser,
   // tdata: vcpu_id[15:0] run_state[17:16] host_cpu[20:18] vcpu_priority[28:21]
   //        affinity_mask[36:29] idle_time_ns[100:37] sample_period_ns[164:101]
   input  wire logic [167:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tuser: answer_kind
   output logic [0:0]       rsp_tuser,
   // tdata: chosen_cpu[2:0] migrate[3] moved_vcpu[19:4] from_cpu[22:20]
   //        to_cpu[25:23] table_full[26]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import vlb_pkg::*;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_REC, S_DIV, S_QRY, S_SUM, S_BSCAN, S_DEC,
      S_RD, S_CHK, S_MV1, S_MV2, S_OUT
   } state_type;

   state_type   st_ff, st_in;
   logic [2:0]  cur_ff;
   logic [7:0]  mask_ff;
   logic [6:0]  busy_ff, gap_ff;

   // captured request
   logic [1:0]  kind_ff, kind_in;
   rec_type     rq_ff, rq_in;
   logic [63:0] idl_ff, idl_in, per_ff, per_in;

   // table memory
   rec_type     tbl [VCPU_SLOTS];
   rec_type     trd_ff;
   logic [SW-1:0] taddr;
   logic        twe;
   rec_type     twd;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;

   // count memories (alive, active), one port each
   logic [6:0]  alv [NCNT];
   logic [6:0]  act [NCNT];
   logic [6:0]  alv_rd_ff, act_rd_ff;
   logic [NW-1:0] caddr;
   logic        cwe;
   logic [6:0]  alv_wd, act_wd;

   logic [6:0]  pct_ff [HOST_CPUS];

   // scan
   logic [CW-1:0] i_ff, i_in;
   logic [PW:0]   p_ff, p_in;
   logic [HW:0]   h_ff, h_in;
   logic [9:0]    sum_ff, sum_in;
   logic [9:0]    asum_ff [HOST_CPUS];
   logic          asum_we;
   logic [2:0]    best_ff, best_in, worst_ff, worst_in;
   logic [6:0]    bi_ff, bi_in, wi_ff, wi_in;
   logic [9:0]    wc_ff, wc_in;
   logic [6:0]    bc_ff, bc_in;
   logic          mig_ff, mig_in;
   logic [15:0]   mid_ff, mid_in;
   logic          vld_ff, vld_in;
   logic [1:0]    ph_ff, ph_in;

   div_req_type dq;
   div_rsp_type ds;

   vlb_pct u_pct (.clock(clock), .reset(reset), .div_req(dq), .div_rsp(ds));

   function automatic logic [NW-1:0] cidx(input logic [HW-1:0] h, input logic [PW-1:0] p);
      return NW'(h) * NW'(PRIORITY_LEVELS) + NW'(p);
   endfunction

   function automatic logic on(input logic [HW:0] h, input logic [7:0] m);
      return (h < (HW+1)'(HOST_CPUS)) && (h < (HW+1)'(8)) && m[h[2:0]];
   endfunction

   logic rq_cnt;
   assign rq_cnt = (rq_ff.state != ST_OTHER) && (32'(rq_ff.host) < HOST_CPUS)
                   && (32'(rq_ff.prio) < PRIORITY_LEVELS);
   logic [6:0] pct_h;
   assign pct_h = pct_ff[h_ff[HW-1:0]];

   assign req_tready = (st_ff == S_IDLE) && !vld_ff;
   assign dq.idle    = idl_ff;
   assign dq.period  = per_ff;
   assign dq.start   = (st_ff == S_DIV) && (ph_ff == 2'd0);

   always_comb begin
      st_in = st_ff; kind_in = kind_ff; rq_in = rq_ff; idl_in = idl_ff; per_in = per_ff;
      cnt_in = cnt_ff; ovf_in = ovf_ff; i_in = i_ff; p_in = p_ff; h_in = h_ff;
      sum_in = sum_ff; best_in = best_ff; worst_in = worst_ff; bi_in = bi_ff;
      wi_in = wi_ff; wc_in = wc_ff; bc_in = bc_ff; mig_in = mig_ff; mid_in = mid_ff;
      vld_in = vld_ff; ph_in = ph_ff; asum_we = 1'b0;
      taddr = i_ff[SW-1:0]; twe = 1'b0; twd = rq_ff;
      caddr = '0; cwe = 1'b0; alv_wd = '0; act_wd = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (st_ff)
         S_CLR: begin
            // sweep both count tables
            caddr = i_ff[NW-1:0]; cwe = 1'b1;
            i_in = i_ff + 1'b1;
            if (32'(i_ff) == NCNT - 1) begin
               i_in = '0; st_in = (kind_ff == REQ_RECORD && ph_ff == 2'd1) ? S_REC : S_IDLE;
               ph_in = 2'd0;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_tuser[1:0];
               rq_in = '{id: req_tdata[15:0], state: req_tdata[17:16],
                         host: req_tdata[20:18], prio: req_tdata[28:21],
                         aff: req_tdata[36:29]};
               idl_in = req_tdata[100:37]; per_in = req_tdata[164:101];
               ph_in = 2'd0; i_in = '0; h_in = '0; mig_in = 1'b0; mid_in = '0;
               unique case (req_tuser[1:0])
                  REQ_RECORD: begin
                     if (req_tuser[2]) begin
                        cnt_in = '0; ovf_in = 1'b0; st_in = S_CLR; ph_in = 2'd1;
                     end else st_in = S_REC;
                  end
                  REQ_IDLE:  st_in = S_DIV;
                  REQ_QUERY: begin
                     st_in = S_QRY; best_in = cur_ff; bc_in = '0;
                  end
                  default: begin
                     st_in = S_SUM; p_in = '0; sum_in = '0;
                  end
               endcase
            end
         end
         S_REC: begin
            // store record (or flag overflow if the table is full), then read-modify-write its counts
            caddr = cidx(rq_ff.host[HW-1:0], rq_ff.prio[PW-1:0]);
            if (ph_ff == 2'd0) begin
               if (32'(cnt_ff) >= VCPU_SLOTS) begin
                  ovf_in = 1'b1; st_in = S_IDLE;
               end else begin
                  taddr = cnt_ff[SW-1:0]; twe = 1'b1; cnt_in = cnt_ff + 1'b1;
                  ph_in = 2'd1;
               end
            end else if (ph_ff == 2'd1) ph_in = 2'd2;
            else begin
               if (rq_cnt) begin
                  cwe = 1'b1; alv_wd = alv_rd_ff + 7'd1;
                  act_wd = (rq_ff.state != ST_PAUSED) ? act_rd_ff + 7'd1 : act_rd_ff;
               end
               st_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (32'(rq_ff.host) >= HOST_CPUS) st_in = S_IDLE;
            else if (ph_ff == 2'd0) ph_in = 2'd1;
            else if (ds.done) st_in = S_IDLE;
         end
         S_QRY: begin
            // ph 0: address issued, 1: data back
            if (32'(rq_ff.prio) >= PRIORITY_LEVELS) begin
               vld_in = 1'b1; st_in = S_OUT;
            end else if (ph_ff == 2'd0) begin
               caddr = cidx(cur_ff[HW-1:0], rq_ff.prio[PW-1:0]); ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               bc_in = (32'(cur_ff) < HOST_CPUS) ? alv_rd_ff : 7'd0;
               caddr = cidx(h_ff[HW-1:0], rq_ff.prio[PW-1:0]); ph_in = 2'd2;
            end else begin
               if (on(h_ff, mask_ff) && alv_rd_ff < bc_ff) begin
                  best_in = 3'(h_ff); bc_in = alv_rd_ff;
               end
               h_in = h_ff + 1'b1;
               caddr = cidx(h_in[HW-1:0], rq_ff.prio[PW-1:0]);
               if (32'(h_ff) == HOST_CPUS - 1) begin
                  vld_in = 1'b1; st_in = S_OUT;
               end
            end
         end
         S_SUM: begin
            // active sum per host, one count per cycle
            caddr = cidx(h_ff[HW-1:0], p_ff[PW-1:0]);
            if (ph_ff == 2'd0) ph_in = 2'd1;
            else begin
               sum_in = sum_ff + 10'(act_rd_ff);
               if (32'(p_ff) == PRIORITY_LEVELS - 1) begin
                  asum_we = 1'b1; sum_in = '0; p_in = '0; ph_in = 2'd0;
                  h_in = h_ff + 1'b1;
                  if (32'(h_ff) == HOST_CPUS - 1) begin
                     h_in = '0; st_in = S_BSCAN;
                     best_in = cur_ff; worst_in = cur_ff;
                     bi_in = (32'(cur_ff) < HOST_CPUS) ? pct_ff[cur_ff[HW-1:0]] : 7'd0;
                     wi_in = bi_in;
                  end
               end else begin
                  p_in = p_ff + 1'b1; caddr = cidx(h_ff[HW-1:0], p_in[PW-1:0]);
               end
            end
            if (st_ff == S_SUM && ph_ff == 2'd0) caddr = cidx(h_ff[HW-1:0], p_ff[PW-1:0]);
         end
         S_BSCAN: begin
            if (h_ff == '0)
               wc_in = (32'(cur_ff) < HOST_CPUS) ? asum_ff[cur_ff[HW-1:0]] : 10'd0;
            if (on(h_ff, mask_ff)) begin
               if (pct_h > bi_ff) begin best_in = 3'(h_ff); bi_in = pct_h; end
               if (pct_h < wi_ff || (pct_h == wi_ff &&
                   asum_ff[h_ff[HW-1:0]] > ((h_ff == '0) ? wc_in : wc_ff))) begin
                  worst_in = 3'(h_ff); wi_in = pct_h; wc_in = asum_ff[h_ff[HW-1:0]];
               end
            end
            h_in = h_ff + 1'b1;
            if (32'(h_ff) == HOST_CPUS - 1) st_in = S_DEC;
         end
         S_DEC: begin
            if (best_ff == worst_ff || wi_ff > busy_ff ||
                8'(bi_ff) < 8'(wi_ff) + 8'(gap_ff)) begin
               vld_in = 1'b1; st_in = S_OUT;
            end else begin
               p_in = '0; i_in = '0; st_in = S_RD;
            end
         end
         S_RD: begin
            // table scan, priority outer
            if (32'(p_ff) >= PRIORITY_LEVELS) begin
               vld_in = 1'b1; st_in = S_OUT;
            end else if (i_ff >= cnt_ff) begin
               i_in = '0; p_in = p_ff + 1'b1;
            end else begin
               taddr = i_ff[SW-1:0]; st_in = S_CHK;
            end
         end
         S_CHK: begin
            if (trd_ff.prio == 8'(p_ff) && trd_ff.host == worst_ff &&
                trd_ff.state == ST_READY && pop8(trd_ff.aff) >= 4'd2 &&
                trd_ff.aff[best_ff]) begin
               rq_in = trd_ff; st_in = S_MV1; ph_in = 2'd0;
               mig_in = 1'b1; mid_in = trd_ff.id;
            end else begin
               i_in = i_ff + 1'b1; st_in = S_RD;
            end
         end
         S_MV1: begin
            // decrement counts at old host
            caddr = cidx(worst_ff[HW-1:0], rq_ff.prio[PW-1:0]);
            if (ph_ff == 2'd0) ph_in = 2'd1;
            else begin
               if (32'(worst_ff) < HOST_CPUS) begin
                  cwe = 1'b1; alv_wd = alv_rd_ff - 7'd1; act_wd = act_rd_ff - 7'd1;
               end
               taddr = i_ff[SW-1:0]; twe = 1'b1;
               twd = rq_ff; twd.host = best_ff;
               ph_in = 2'd0; st_in = S_MV2;
            end
         end
         S_MV2: begin
            caddr = cidx(best_ff[HW-1:0], rq_ff.prio[PW-1:0]);
            if (ph_ff == 2'd0) ph_in = 2'd1;
            else if (ph_ff == 2'd1) ph_in = 2'd2;
            else begin
               if (32'(best_ff) < HOST_CPUS) begin
                  cwe = 1'b1; alv_wd = alv_rd_ff + 7'd1; act_wd = act_rd_ff + 7'd1;
               end
               vld_in = 1'b1; st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!vld_ff || rsp_tready) st_in = S_IDLE;
            if (vld_ff && rsp_tready) st_in = S_IDLE;
            if (vld_ff && !rsp_tready) st_in = S_OUT;
            if (!vld_ff) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (twe) tbl[taddr] <= twd;
      trd_ff <= tbl[taddr];
      if (cwe) begin
         alv[caddr] <= alv_wd; act[caddr] <= act_wd;
      end
      alv_rd_ff <= alv[caddr]; act_rd_ff <= act[caddr];
      if (asum_we) asum_ff[h_ff[HW-1:0]] <= sum_ff + 10'(act_rd_ff);
      rq_ff <= rq_in; idl_ff <= idl_in; per_ff <= per_in;
      p_ff <= p_in; h_ff <= h_in; sum_ff <= sum_in;
      best_ff <= best_in; worst_ff <= worst_in; bi_ff <= bi_in; wi_ff <= wi_in;
      wc_ff <= wc_in; bc_ff <= bc_in; mig_ff <= mig_in; mid_ff <= mid_in;
      if (reset) begin
         st_ff <= S_CLR; i_ff <= '0; ph_ff <= 2'd0; kind_ff <= REQ_IDLE;
         cnt_ff <= '0; ovf_ff <= 1'b0; vld_ff <= 1'b0;
         cur_ff <= 3'd0; mask_ff <= 8'd1; busy_ff <= 7'd50; gap_ff <= 7'd10;
         for (int k = 0; k < HOST_CPUS; k++) pct_ff[k] <= '0;
      end else begin
         st_ff <= st_in; i_ff <= i_in; ph_ff <= ph_in; kind_ff <= kind_in;
         cnt_ff <= cnt_in; ovf_ff <= ovf_in; vld_ff <= vld_in;
         if (st_ff == S_DIV && ph_ff == 2'd1 && ds.done)
            pct_ff[rq_ff.host[HW-1:0]] <= ds.pct;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CUR:  cur_ff  <= csr_wdata[2:0];
               CSR_MASK: mask_ff <= csr_wdata;
               CSR_BUSY: busy_ff <= csr_wdata[6:0];
               CSR_GAP:  gap_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   logic bal;
   assign bal = (kind_ff == REQ_BAL);
   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = bal;
   assign rsp_tdata  = {5'd0, ovf_ff,
                        bal ? best_ff : 3'd0,
                        bal ? worst_ff : 3'd0,
                        bal ? mid_ff : 16'd0,
                        bal & mig_ff,
                        bal ? 3'd0 : best_ff};
endmodule
`default_nettype wire

>>> sv/vlb_pct.sv
`default_nettype none
// Idle percent: one accumulate-or-subtract step per cycle, 100 steps.
module vlb_pct (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vlb_pkg::div_req_type div_req,
   output vlb_pkg::div_rsp_type      div_rsp
);
   import vlb_pkg::*;

   logic [63:0] rem_ff, rem_in, gap_ff, gap_in, idl_ff, idl_in;
   logic [6:0]  q_ff, q_in, n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in = rem_ff; gap_in = gap_ff; idl_in = idl_ff;
      q_in = q_ff; n_in = n_ff; busy_in = busy_ff; done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0; q_in = '0; n_in = '0;
         gap_in = div_req.period - div_req.idle; idl_in = div_req.idle;
         if (div_req.period == 64'd0) begin
            done_in = 1'b1;
         end else if (div_req.idle >= div_req.period) begin
            q_in = PCT_FULL; done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // one step of the quotient
         if (rem_ff >= gap_ff) begin
            rem_in = rem_ff - gap_ff; q_in = q_ff + 7'd1;
         end else begin
            rem_in = rem_ff + idl_ff;
         end
         n_in = n_ff + 7'd1;
         if (n_ff == PCT_FULL - 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; gap_ff <= gap_in; idl_ff <= idl_in;
      q_ff <= q_in; n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.pct  = q_ff;
endmodule
`default_nettype wire

>>> bench/vcpu_load_balancer_test.sv
`default_nettype none
module vcpu_load_balancer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vlb_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [2:0] req_tuser;
   logic [167:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [0:0] rsp_tuser;
   logic [31:0] rsp_tdata;
   logic csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   vcpu_load_balancer uut (.*);

   typedef struct packed {
      logic       kind;
      logic [2:0] chosen;
      logic       migrate;
      logic [15:0] moved;
      logic [2:0] from_h;
      logic [2:0] to_h;
      logic       full;
   } answer_t;

   // predictor copy of the block state
   int unsigned cur_host, online, busy_lim, gap_min;
   rec_type     slots [VCPU_SLOTS];
   int unsigned loaded;
   int unsigned alive [HOST_CPUS][PRIORITY_LEVELS];
   int unsigned active [HOST_CPUS][PRIORITY_LEVELS];
   int unsigned idle_pct [HOST_CPUS];
   bit          overflow;

   answer_t pending_answers[$];
   int errors = 0;
   int answers_seen = 0;
   longint cycles = 0;
   bit quiet = 0;         // no idling in the last part
   bit hold_rsp = 0;      // long receiver hold-off request
   localparam longint CYCLE_LIMIT = 4_000_000;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("vcpu_load_balancer_test failed");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic void count_record(input rec_type r, input bit add);
      if (r.state == ST_OTHER || r.host >= HOST_CPUS || r.prio >= PRIORITY_LEVELS) return;
      if (add) begin
         alive[r.host][r.prio]++;
         if (r.state != ST_PAUSED) active[r.host][r.prio]++;
      end else begin
         alive[r.host][r.prio]--;
         if (r.state != ST_PAUSED) active[r.host][r.prio]--;
      end
   endfunction

   function automatic int unsigned idle_share(input logic [63:0] idle, input logic [63:0] period);
      logic [64:0] rem;
      logic [64:0] diff;
      int unsigned q;
      rem = 0;
      q = 0;
      if (period == 0) return 0;
      if (idle >= period) return 100;
      diff = period - idle;
      for (int i = 0; i < 100; i++) begin
         if (rem >= diff) begin
            rem -= diff;
            q++;
         end else begin
            rem += idle;
         end
      end
      return q;
   endfunction

   function automatic int unsigned active_total(input int unsigned h);
      int unsigned s;
      s = 0;
      for (int p = 0; p < PRIORITY_LEVELS; p++) s += active[h][p];
      return s;
   endfunction

   function automatic bit host_online(input int unsigned h);
      return h < HOST_CPUS && online[h];
   endfunction

   // work out the answer (if any) that one request causes
   function automatic void predict(input logic [2:0] user, input logic [167:0] data);
      logic [1:0] kind;
      rec_type r;
      answer_t a;
      int unsigned best, worst, bi, wi, wc, bc;
      bit done;
      kind = user[1:0];
      r = '{id: data[15:0], state: data[17:16], host: data[20:18], prio: data[28:21],
            aff: data[36:29]};
      a = '0;
      done = 0;
      if (kind == REQ_RECORD) begin
         if (user[2]) begin
            loaded = 0;
            overflow = 0;
            foreach (alive[h, p]) begin
               alive[h][p] = 0;
               active[h][p] = 0;
            end
         end
         if (loaded >= VCPU_SLOTS) overflow = 1;
         else begin
            slots[loaded] = r;
            loaded++;
            count_record(r, 1);
         end
         return;
      end
      if (kind == REQ_IDLE) begin
         idle_pct[r.host] = idle_share(data[100:37], data[164:101]);
         return;
      end
      a.full = overflow;
      if (kind == REQ_QUERY) begin
         best = cur_host;
         if (r.prio < PRIORITY_LEVELS) begin
            bc = alive[best][r.prio];
            for (int h = 0; h < HOST_CPUS; h++)
               if (host_online(h) && alive[h][r.prio] < bc) begin
                  best = h;
                  bc = alive[h][r.prio];
               end
         end
         a.chosen = 3'(best);
         pending_answers.push_back(a);
         return;
      end
      best = cur_host;
      bi = idle_pct[cur_host];
      worst = cur_host;
      wi = bi;
      wc = active_total(cur_host);
      for (int h = 0; h < HOST_CPUS; h++) begin
         if (!host_online(h)) continue;
         if (idle_pct[h] > bi) begin
            best = h;
            bi = idle_pct[h];
         end
         if (idle_pct[h] < wi || (idle_pct[h] == wi && active_total(h) > wc)) begin
            worst = h;
            wi = idle_pct[h];
            wc = active_total(h);
         end
      end
      a.kind = 1;
      a.from_h = 3'(worst);
      a.to_h = 3'(best);
      if (!(best == worst || wi > busy_lim || bi < wi + gap_min)) begin
         for (int p = 0; p < PRIORITY_LEVELS && !done; p++)
            for (int i = 0; i < loaded; i++) begin
               if (slots[i].prio != p || slots[i].host != worst || slots[i].state != ST_READY)
                  continue;
               if ($countones(slots[i].aff) < 2 || !slots[i].aff[best]) continue;
               count_record(slots[i], 0);
               slots[i].host = 3'(best);
               count_record(slots[i], 1);
               a.migrate = 1;
               a.moved = slots[i].id;
               done = 1;
               break;
            end
      end
      pending_answers.push_back(a);
   endfunction

   // receiver: random stalls, a long hold-off on request
   initial begin
      int n;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (3000) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 17);
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // check each answer against the oldest prediction
   always @(posedge clock) begin
      answer_t want;
      logic [31:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         answers_seen++;
         if (pending_answers.size() == 0) report("unexpected answer", got, 0);
         else begin
            want = pending_answers.pop_front();
            if (rsp_tuser[0] !== want.kind) report("answer_kind", rsp_tuser, want.kind);
            if (got[2:0] !== want.chosen) report("chosen_cpu", got[2:0], want.chosen);
            if (got[3] !== want.migrate) report("migrate", got[3], want.migrate);
            if (got[19:4] !== want.moved) report("moved_vcpu", got[19:4], want.moved);
            if (got[22:20] !== want.from_h) report("from_cpu", got[22:20], want.from_h);
            if (got[25:23] !== want.to_h) report("to_cpu", got[25:23], want.to_h);
            if (got[26] !== want.full) report("table_full", got[26], want.full);
         end
      end
   end

   // valid stays high after the transaction; the next send or a drain moves it
   task automatic send(input logic [1:0] kind, input bit first, input logic [15:0] id,
                       input logic [1:0] st, input logic [2:0] host, input logic [7:0] prio,
                       input logic [7:0] aff, input logic [63:0] idle, input logic [63:0] period);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 17);
         req_tvalid <= 0;
         repeat (n) @(negedge clock);
      end
      req_tuser <= {first, kind};
      req_tdata <= {3'b0, period, idle, aff, prio, host, st, id};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict({first, kind}, {3'b0, period, idle, aff, prio, host, st, id});
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (PRIORITY_LEVELS * (VCPU_SLOTS + 1) + 300) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         CSR_CUR:  cur_host = val[2:0];
         CSR_MASK: online = val;
         CSR_BUSY: busy_lim = val[6:0];
         default:  gap_min = val[6:0];
      endcase
   endtask

   task automatic set_config(input int c, input int m, input int b, input int g);
      drain();
      write_csr(CSR_CUR, 8'(c));
      write_csr(CSR_MASK, 8'(m));
      write_csr(CSR_BUSY, 8'(b));
      write_csr(CSR_GAP, 8'(g));
      csr_we <= 0;
   endtask

   task automatic rand_record(input bit first);
      send(REQ_RECORD, first, 16'($urandom), 2'($urandom), 3'($urandom),
           8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, PRIORITY_LEVELS - 1)),
           8'($urandom), 0, 0);
   endtask

   task automatic rand_idle();
      logic [63:0] per, idl;
      case ($urandom_range(0, 4))
         0: begin per = {$urandom, $urandom}; idl = {$urandom, $urandom}; end
         1: begin per = 0; idl = 64'($urandom); end
         default: begin
            per = 64'($urandom_range(1, 100000));
            idl = 64'($urandom_range(0, 32'(per)));
         end
      endcase
      send(REQ_IDLE, 1'($urandom), 16'($urandom), 2'($urandom), 3'($urandom),
           8'($urandom), 8'($urandom), idl, per);
   endtask

   task automatic rand_query();
      send(REQ_QUERY, 1'($urandom), 16'($urandom), 2'($urandom), 3'($urandom),
           8'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, PRIORITY_LEVELS - 1)),
           8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic rand_balance();
      send(REQ_BAL, 1'($urandom), 16'($urandom), 2'($urandom), 3'($urandom),
           8'($urandom), 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   // extremes of each field, every request kind and the special cases
   task automatic test_directed();
      send(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_BAL, 0, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_RECORD, 1, 16'hffff, ST_READY, 3'd7, 8'd0, 8'hff, '1, '1);
      send(REQ_RECORD, 0, 16'h0001, ST_PAUSED, 3'd0, 8'd7, 8'h01, 0, 0);
      send(REQ_RECORD, 0, 16'h0002, ST_OTHER, 3'd1, 8'd3, 8'h03, 0, 0);
      send(REQ_RECORD, 0, 16'h0003, 2'd2, 3'd2, 8'hff, 8'h80, 0, 0);
      send(REQ_IDLE, 0, 0, 0, 3'd7, 0, 0, 64'd90, 64'd100);
      send(REQ_IDLE, 1, 0, 0, 3'd0, 0, 0, '1, '1);
      send(REQ_IDLE, 0, 0, 0, 3'd1, 0, 0, 64'd5, 64'd0);
      send(REQ_IDLE, 0, 0, 0, 3'd2, 0, 0, 64'h8000_0000_0000_0001, '1);
      send(REQ_IDLE, 0, 0, 0, 3'd3, 0, 0, 64'd0, 64'd7);
      send(REQ_QUERY, 0, 0, 0, 0, 8'hff, 0, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 8'd7, 0, 0, 0);
   endtask

   task automatic test_balance_moves();
      set_config(1, 8'hff, 100, 0);
      send(REQ_IDLE, 0, 0, 0, 3'd7, 0, 0, 64'd99, 64'd100);
      send(REQ_IDLE, 0, 0, 0, 3'd0, 0, 0, 64'd1, 64'd100);
      send(REQ_RECORD, 1, 16'h1234, ST_READY, 3'd0, 8'd2, 8'h81, 0, 0);
      send(REQ_RECORD, 0, 16'h2345, ST_READY, 3'd0, 8'd1, 8'h80, 0, 0);
      send(REQ_RECORD, 0, 16'h3456, ST_READY, 3'd0, 8'd1, 8'hc1, 0, 0);
      send(REQ_BAL, 0, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_BAL, 0, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_BAL, 0, 0, 0, 0, 0, 0, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 8'd1, 0, 0, 0);
   endtask

   // fill the table past its size so later records drop
   task automatic test_overflow();
      set_config(7, 8'haa, 0, 100);
      rand_record(1);
      repeat (VCPU_SLOTS + 3) rand_record(0);
      rand_query();
      rand_balance();
      rand_record(1);
      rand_query();
   endtask

   // hold off the receiver while requests keep coming
   task automatic test_backpressure();
      hold_rsp = 1;
      repeat (40) begin
         rand_query();
         rand_record(0);
      end
   endtask

   task automatic test_random(input int items, input int c, input int m, input int b,
                              input int g);
      set_config(c, m, b, g);
      for (int i = 0; i < items; i++) begin
         if (i % 60 == 0) rand_record(1);
         else case ($urandom_range(0, 9))
            0, 1, 2, 3: rand_record(0);
            4, 5: rand_idle();
            6, 7: rand_query();
            default: rand_balance();
         endcase
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = 0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      cur_host = 0;
      online = 1;
      busy_lim = 50;
      gap_min = 10;
      loaded = 0;
      overflow = 0;
      foreach (alive[h, p]) begin
         alive[h][p] = 0;
         active[h][p] = 0;
      end
      foreach (idle_pct[h]) idle_pct[h] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_balance_moves();
      test_overflow();
      test_backpressure();
      test_random(400, 0, 8'hff, 100, 0);
      test_random(400, 3, 8'h5b, 50, 10);
      test_random(300, 5, 8'h00, 0, 100);
      test_random(300, 2, 8'hff, 80, 5);
      quiet = 1;
      test_random(250, 6, 8'hf3, 100, 1);
      drain();
      if (errors == 0 && pending_answers.size() == 0)
         $display("vcpu_load_balancer_test passed");
      else
         $display("vcpu_load_balancer_test failed");
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
sv/vlb_pkg.sv
sv/vlb_pct.sv
sv/vcpu_load_balancer.sv
bench/vcpu_load_balancer_test.sv
